// ===== hdl/fifo_list_with_insert_after_macros.svh =====
// Assertion macros shared by the list design.
`ifndef FIFO_LIST_WITH_INSERT_AFTER_MACROS_SVH
`define FIFO_LIST_WITH_INSERT_AFTER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FLA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define FLA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fla_pkg.sv =====
// Types and constants of the ordered list with insert-after.
package fla_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int OUT_COUNT_W   = 11;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_INSERT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_DATA,
      ST_SEARCH,
      ST_SHIFT,
      ST_WRITE_NEW,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
      logic signed [31:0] target;
   } fla_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [31:0]       popped_value;
      logic                     is_empty;
      logic [OUT_COUNT_W-1:0]   entry_count;
   } fla_rsp_type;

endpackage

// ===== hdl/fla_chan_if.sv =====
// Valid/ready channel interface carrying one item of a given payload type.
interface fla_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/fifo_list_with_insert_after.sv =====
// Ordered list of signed 32-bit values with push, pop and insert-after.
//
// Requests arrive on req_chan (mode, value, target) and each one yields
// exactly one item on rsp_chan (status, popped_value, is_empty, entry_count).
// Both channels use valid/ready; an item moves at a clock edge where both
// are high. The block works on one request at a time: req_chan.ready is
// high only while the sequencer is idle.
// Entries live in a single-port-write, single-port-read ring memory with a
// head pointer, so at most one memory read and one write happen per cycle.
// Path from request accept to rsp_chan.valid:
//   push, unused mode, or any full/empty rejection: straight to the response
//   pop: one memory read, then the response
//   insert-after: one search step per entry searched, then, when found, one
//     shift step per entry moved back and one write of the new value.
// After the response is taken the block returns to idle, where it can take
// the next request. The memory read port, used once per cycle by search and
// shift, paces insert-after.
// Reset (synchronous, active high) empties the list; memory contents are
// not cleared, since only held entries are ever read.
// If the receiver stalls, the response is held stable in the output
// register and no new request is accepted until it is taken.
module fifo_list_with_insert_after
   import fla_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   fla_chan_if.sink   req_chan,
   fla_chan_if.source rsp_chan
);

`include "fifo_list_with_insert_after_macros.svh"

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SUM_W = AW + 1;
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
   localparam logic [CW-1:0]    DEPTH_C = CW'(DEPTH);

   // Control state.
   state_type        state_ff,  state_in;
   logic [AW-1:0]    head_ff,   head_in;
   logic [CW-1:0]    count_ff,  count_in;
   // idx_ff walks the search and then holds the match position.
   logic [AW-1:0]    idx_ff,    idx_in;
   // sh_ff is the destination offset of the current shift step.
   logic [AW-1:0]    sh_ff,     sh_in;

   // Latched request payload and registered response.
   logic signed [31:0] value_ff,  value_in;
   logic signed [31:0] target_ff, target_in;
   fla_rsp_type        rsp_ff,    rsp_in;

   // Ring memory.
   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      wr_off, rd_off;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic signed [31:0] wr_data;

   logic               req_fire;
   logic               rsp_fire;

   // Offset from the head, wrapped into the ring. Offsets stay below DEPTH.
   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[AW-1:0];
   endfunction

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = (state_ff == ST_RESP);
   assign rsp_chan.payload = rsp_ff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   assign wr_addr = ring_addr(head_ff, wr_off);
   assign rd_addr = ring_addr(head_ff, rd_off);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      sh_in     = sh_ff;
      value_in  = value_ff;
      target_in = target_ff;
      rsp_in    = rsp_ff;
      mem_we    = 1'b0;
      wr_off    = sh_ff;
      wr_data   = value_ff;
      rd_off    = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               value_in            = req_chan.payload.value;
               target_in           = req_chan.payload.target;
               rsp_in.status       = STAT_OK;
               rsp_in.popped_value = '0;
               state_in            = ST_RESP;
               case (req_chan.payload.mode)
                  MODE_PUSH: begin
                     if (count_ff == DEPTH_C) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        wr_off   = AW'(count_ff);
                        wr_data  = req_chan.payload.value;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_POP: begin
                     if (count_ff == '0) begin
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        rd_off   = '0;
                        state_in = ST_POP_DATA;
                     end
                  end
                  MODE_INSERT: begin
                     // Fullness is checked before the search.
                     if (count_ff == DEPTH_C) begin
                        rsp_in.status = STAT_FULL;
                     end else if (count_ff == '0) begin
                        rsp_in.status = STAT_NOT_FOUND;
                     end else begin
                        idx_in   = '0;
                        rd_off   = '0;
                        state_in = ST_SEARCH;
                     end
                  end
                  default: begin
                     // The unused mode leaves the list alone.
                     rsp_in.status = STAT_OK;
                  end
               endcase
            end
         end

         ST_POP_DATA: begin
            rsp_in.popped_value = rd_data_ff;
            head_in             = ring_addr(head_ff, AW'(1));
            count_in            = count_ff - 1'b1;
            state_in            = ST_RESP;
         end

         ST_SEARCH: begin
            // rd_data_ff holds the entry at offset idx_ff.
            if (rd_data_ff == target_ff) begin
               sh_in = AW'(count_ff);
               if (CW'({1'b0, idx_ff} + 1'b1) == count_ff) begin
                  // Match at the tail: the new value becomes the tail.
                  state_in = ST_WRITE_NEW;
               end else begin
                  rd_off   = AW'(count_ff - 1'b1);
                  state_in = ST_SHIFT;
               end
            end else if (CW'({1'b0, idx_ff} + 1'b1) == count_ff) begin
               rsp_in.status = STAT_NOT_FOUND;
               state_in      = ST_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
               rd_off = idx_ff + 1'b1;
            end
         end

         ST_SHIFT: begin
            // Move entry sh_ff-1 back to sh_ff, walking toward the match.
            mem_we  = 1'b1;
            wr_off  = sh_ff;
            wr_data = rd_data_ff;
            sh_in   = sh_ff - 1'b1;
            if (({1'b0, sh_ff} - 1'b1) == ({1'b0, idx_ff} + 1'b1)) begin
               state_in = ST_WRITE_NEW;
            end else begin
               rd_off = sh_ff - 1'b1 - 1'b1;
            end
         end

         ST_WRITE_NEW: begin
            mem_we        = 1'b1;
            wr_off        = sh_ff;
            wr_data       = value_ff;
            count_in      = count_ff + 1'b1;
            rsp_in.status = STAT_OK;
            state_in      = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Count and empty flag reflect the list after the request.
      if ((state_in == ST_RESP) && (state_ff != ST_RESP)) begin
         rsp_in.is_empty    = (count_in == '0);
         rsp_in.entry_count = OUT_COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         sh_ff    <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         sh_ff    <= sh_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      target_ff <= target_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   `FLA_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C,
                   "entry count exceeds depth")
   `FLA_ASSERT_IMP(a_one_side, clock, reset, req_chan.ready, !rsp_chan.valid,
                   "request accepted while a response is pending")
   `FLA_ASSERT_NXT(a_pop_count, clock, reset, state_ff == ST_POP_DATA,
                   count_ff == $past(count_ff) - 1'b1, "pop did not drop the count")
   `FLA_ASSERT_IMP(a_search_range, clock, reset, state_ff == ST_SEARCH,
                   CW'(idx_ff) < count_ff, "search index beyond held entries")
   `FLA_ASSERT_IMP(a_empty_flag, clock, reset, rsp_chan.valid,
                   rsp_chan.payload.is_empty == (rsp_chan.payload.entry_count == '0),
                   "empty flag disagrees with entry count")

endmodule
